@@ rtl/ipt_pkg.sv @@
// Package for the interval progress timer: mode and command codes, reset
// constants and the reciprocal used for the blink phase arithmetic.
// No dependencies.
package ipt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_DONE    = 2'd2,
        MODE_PAUSED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BTN_A = 2'd1,
        CMD_BTN_B = 2'd2
    } t_cmd;

    localparam int          CELL_COUNT_DEFAULT = 25;
    localparam logic [31:0] STEP_INTERVAL_RST  = 32'd60000;

    // Levels
    localparam logic [5:0] CURSOR_ON = 6'd32;
    localparam logic [7:0] FLASH_ON  = 8'd255;

    // Beep requests
    localparam logic [1:0] BEEP_NONE   = 2'd0;
    localparam logic [1:0] BEEP_BUTTON = 2'd1;
    localparam logic [1:0] BEEP_FINISH = 2'd3;

    // t mod 2000 = 16 * ((t >> 4) mod 125) + t[3:0]
    localparam int          DIV_SHIFT = 35;
    localparam logic [28:0] RECIP_125 = 29'((64'd1 << DIV_SHIFT) / 64'd125);
    localparam logic [7:0]  DIV_125   = 8'd125;

    // Blink thresholds on t mod 2000
    localparam logic [10:0] CURSOR_OFF_ABOVE = 11'd1000;
    localparam logic [10:0] FLASH_OFF_LO0    = 11'd501;
    localparam logic [10:0] FLASH_OFF_HI0    = 11'd999;
    localparam logic [10:0] FLASH_OFF_LO1    = 11'd1501;

endpackage

@@ rtl/interval_progress_timer.sv @@
// Interval progress timer top level: command decode, mode state, cell count
// and blink phase pipeline. Depends on ipt_pkg.
//
// Usage
//   Slave stream: one transfer per event. tuser carries the command
//   (time tick, button A, button B), tdata the millisecond time stamp,
//   which only tick transfers use.
//   Master stream: one status transfer per input transfer, in order:
//   mode, lit cell count, cursor level, flash level, beep and clear requests.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the step interval; write
//   only while the block is empty.
// Timing
//   Path: the input transfer passes the input register; state update and
//   quotient multiply; remainder; level decode into the output register.
//   Throughput: one transfer per cycle while m_axis_tready stays high. The loop-carried state (mode, time
//   since last cell, cell count) is one 32-bit add and compare per item.
// Stall
//   Each stage has its own valid bit and advances when the next one is free,
//   so bubbles are squeezed out and s_axis_tready stays high while the
//   output register holds an untaken result, until all stages are full.
// Reset
//   i_rst_n (synchronous, active low) empties the pipeline, returns to idle
//   with no cells lit, forgets the last tick and sets the interval to 60000.
module interval_progress_timer #(
    parameter int CELL_COUNT = ipt_pkg::CELL_COUNT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,   // step_interval_ms

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] now_ms
    input  logic [1:0]  s_axis_tuser,    // [1:0] command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // [1:0] mode, [6:2] lit_count,
                                         // [12:7] cursor_level, [20:13] flash_level,
                                         // [22:21] beep_count, [23] clear_display
);

    localparam logic [4:0] CELL_LAST = 5'(CELL_COUNT);

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when empty or when it drains.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic en1, en2, en3, en_out;

    assign en_out        = !r_out_valid || m_axis_tready;
    assign en3           = !r_v3 || en_out;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign m_axis_tvalid = r_out_valid;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && en1;

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [31:0] r_step_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= ipt_pkg::STEP_INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            r_step_interval <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: last tick time tracked at the transfer, so elapsed time
    // and the display time are known before the state update.
    // ------------------------------------------------------------------
    ipt_pkg::t_cmd in_cmd;
    logic          in_tick;
    logic [31:0]   r_last_t;
    logic          r_primed;
    ipt_pkg::t_cmd r_cmd1;
    logic [31:0]   r_dt1;
    logic [31:0]   r_t1;

    assign in_cmd  = ipt_pkg::t_cmd'(s_axis_tuser);
    assign in_tick = (in_cmd == ipt_pkg::CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_t <= '0;
            r_primed <= 1'b0;
            r_v1     <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (in_xfer && in_tick) begin
                r_last_t <= s_axis_tdata;
                r_primed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd1 <= in_cmd;
            r_dt1  <= (in_tick && r_primed) ? (s_axis_tdata - r_last_t) : '0;
            r_t1   <= in_tick ? s_axis_tdata : r_last_t;
        end
    end

    // ------------------------------------------------------------------
    // State update. Only the distance from the last step mark matters,
    // so it is kept as one register instead of run time and mark.
    // ------------------------------------------------------------------
    ipt_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_since, n_since;
    logic [4:0]     r_cells, n_cells;
    logic [1:0]     n_beep;
    logic           n_clear;
    logic [31:0]    since_sum;
    logic [4:0]     cells_inc;
    logic           upd;

    assign upd       = r_v1 && en2;
    assign since_sum = r_since + r_dt1;
    assign cells_inc = r_cells + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ipt_pkg::MODE_IDLE;
            r_since <= '0;
            r_cells <= '0;
        end else if (upd) begin
            r_mode  <= n_mode;
            r_since <= n_since;
            r_cells <= n_cells;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_since = r_since;
        n_cells = r_cells;
        n_beep  = ipt_pkg::BEEP_NONE;
        n_clear = 1'b0;
        unique case (r_cmd1)
            ipt_pkg::CMD_TICK: begin
                if (r_mode == ipt_pkg::MODE_RUNNING) begin
                    if (since_sum > r_step_interval) begin
                        n_cells = cells_inc;
                        n_since = '0;
                        if (cells_inc == CELL_LAST) begin
                            n_mode = ipt_pkg::MODE_DONE;
                            n_beep = ipt_pkg::BEEP_FINISH;
                        end
                    end else begin
                        n_since = since_sum;
                    end
                end
            end
            ipt_pkg::CMD_BTN_B: begin
                unique case (r_mode) inside
                    ipt_pkg::MODE_IDLE, ipt_pkg::MODE_PAUSED: begin
                        n_mode = ipt_pkg::MODE_RUNNING;
                        n_beep = ipt_pkg::BEEP_BUTTON;
                    end
                    ipt_pkg::MODE_RUNNING: begin
                        n_mode = ipt_pkg::MODE_PAUSED;
                        n_beep = ipt_pkg::BEEP_BUTTON;
                    end
                    default: begin
                        n_mode = r_mode;   // done: ignored
                    end
                endcase
            end
            ipt_pkg::CMD_BTN_A: begin
                if (r_mode == ipt_pkg::MODE_PAUSED || r_mode == ipt_pkg::MODE_DONE) begin
                    n_mode  = ipt_pkg::MODE_IDLE;
                    n_since = '0;
                    n_cells = '0;
                    n_beep  = ipt_pkg::BEEP_BUTTON;
                    n_clear = 1'b1;
                end
            end
            default: begin
                n_mode = r_mode;           // unused code: status only
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: reciprocal product for (t >> 4) / 125; only the low quotient
    // byte is needed because the remainder is below 256.
    // ------------------------------------------------------------------
    logic [56:0]    prod;
    logic [7:0]     r_q2;
    logic [11:0]    r_tlo2;
    ipt_pkg::t_mode r_mode2;
    logic [4:0]     r_lit2;
    logic [1:0]     r_beep2;
    logic           r_clr2;

    assign prod = 57'(r_t1[31:4]) * 57'(ipt_pkg::RECIP_125);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_q2    <= prod[ipt_pkg::DIV_SHIFT +: 8];
            r_tlo2  <= r_t1[11:0];
            r_mode2 <= n_mode;
            r_lit2  <= n_cells;
            r_beep2 <= n_beep;
            r_clr2  <= n_clear;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: raw remainder, possibly one divisor too high (quotient
    // estimate can be one short).
    // ------------------------------------------------------------------
    logic [15:0]    q_times;
    logic [7:0]     r_rem3;
    logic [3:0]     r_tlo3;
    ipt_pkg::t_mode r_mode3;
    logic [4:0]     r_lit3;
    logic [1:0]     r_beep3;
    logic           r_clr3;

    assign q_times = 16'(r_q2) * 16'(ipt_pkg::DIV_125);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && en3) begin
            r_rem3  <= r_tlo2[11:4] - q_times[7:0];
            r_tlo3  <= r_tlo2[3:0];
            r_mode3 <= r_mode2;
            r_lit3  <= r_lit2;
            r_beep3 <= r_beep2;
            r_clr3  <= r_clr2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 decode: t mod 2000, then blink levels.
    // ------------------------------------------------------------------
    logic [6:0]  rem125;
    logic [10:0] phase;
    logic [5:0]  cursor_lvl;
    logic [7:0]  flash_lvl;
    logic        flash_off;

    assign rem125    = (r_rem3 >= ipt_pkg::DIV_125) ? 7'(r_rem3 - ipt_pkg::DIV_125)
                                                    : r_rem3[6:0];
    assign phase     = {rem125, r_tlo3};
    // flash is off from 501 to 999 ms of each 1000 ms period
    assign flash_off = (phase >= ipt_pkg::FLASH_OFF_LO0 && phase <= ipt_pkg::FLASH_OFF_HI0)
                    || (phase >= ipt_pkg::FLASH_OFF_LO1);

    always_comb begin
        cursor_lvl = '0;
        flash_lvl  = '0;
        if (r_mode3 == ipt_pkg::MODE_RUNNING && phase <= ipt_pkg::CURSOR_OFF_ABOVE) begin
            cursor_lvl = ipt_pkg::CURSOR_ON;
        end
        if (r_mode3 == ipt_pkg::MODE_DONE && !flash_off) begin
            flash_lvl = ipt_pkg::FLASH_ON;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && en_out) begin
            r_out_data <= {r_clr3, r_beep3, flash_lvl, cursor_lvl, r_lit3, r_mode3};
        end
    end

    assign m_axis_tdata = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cells_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cells <= CELL_LAST)
        else $error("cell count above CELL_COUNT");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[23] |-> r_out_data[1:0] == ipt_pkg::MODE_IDLE
            && r_out_data[6:2] == 5'd0)
        else $error("clear request without return to idle");

    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[22:21] == ipt_pkg::BEEP_FINISH
            |-> r_out_data[1:0] == ipt_pkg::MODE_DONE && r_out_data[6:2] == CELL_LAST)
        else $error("finish beep outside done");

    a_levels_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[20:13] == 8'd0 || r_out_data[1:0] == ipt_pkg::MODE_DONE)
            && (r_out_data[12:7] == 6'd0 || r_out_data[1:0] == ipt_pkg::MODE_RUNNING))
        else $error("level active in wrong mode");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 || !r_v2 || !r_v3 || !r_out_valid |-> s_axis_tready)
        else $error("input stalled with a free stage");

endmodule
